// ===== rtl/core/ntt_pkg.sv =====
// Package for the note-to-tone timing block: register indexes, ratios, widths.
// No dependencies.
package ntt_pkg;

  localparam logic [1:0] REG_BASE_PITCH = 2'd0;
  localparam logic [1:0] REG_TRANSPOSE  = 2'd1;
  localparam logic [1:0] REG_TEMPO      = 2'd2;

  localparam logic [31:0] RATIO_UP_Q30 = 32'd1137589835;
  localparam logic [31:0] RATIO_DN_Q32 = 32'd4053909305;

  localparam logic [21:0] BASE_PITCH_RST = 22'd112640;
  localparam logic [6:0]  TRANSPOSE_RST  = 7'd0;
  localparam logic [9:0]  TEMPO_RST      = 10'd60;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef enum logic [1:0] {B_IDLE, B_DOWN, B_UP} build_t;

endpackage

// ===== rtl/core/ntt_table_build.sv =====
// Note table builder: rebuilds the frequency table one entry a cycle.
// Depends on ntt_pkg. The table is a memory read through one registered port.
module ntt_table_build #(
  parameter int NOTE_COUNT      = 88,
  parameter int REFERENCE_INDEX = 48,
  localparam int IW             = $clog2(NOTE_COUNT)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [21:0]   base_pitch,
  output logic          busy,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [15:0]   rd_data
);
  import ntt_pkg::*;

  build_t        state, state_next;
  logic [31:0]   v;
  logic [31:0]   v_next;
  logic [IW-1:0] idx, idx_next;
  logic          we;
  logic [IW-1:0] waddr;
  logic [15:0]   wdata;
  logic [15:0]   mem [NOTE_COUNT];
  logic [63:0]   prod_dn, prod_up;
  logic [33:0]   up_shift;

  localparam logic [IW-1:0] REF_I  = IW'(REFERENCE_INDEX);
  localparam logic [IW-1:0] LAST_I = IW'(NOTE_COUNT - 1);

  assign prod_dn  = 64'(v) * 64'(RATIO_DN_Q32);
  assign prod_up  = 64'(v) * 64'(RATIO_UP_Q30);
  assign up_shift = prod_up[63:30];
  assign busy     = (state != B_IDLE);

  always_comb begin
    state_next = state;
    v_next     = v;
    idx_next   = idx;
    we         = 1'b0;
    waddr      = idx;
    wdata      = v[31:16];
    unique case (state)
      B_IDLE: begin
        if (start) begin
          // write the reference entry, then walk down, or up when it is entry 0
          v_next   = {2'b00, base_pitch, 8'h00};
          we       = 1'b1;
          waddr    = REF_I;
          wdata    = {2'b00, base_pitch[21:8]};
          idx_next = REF_I;
          if (REFERENCE_INDEX == 0) state_next = B_UP;
          else state_next = B_DOWN;
        end
      end
      B_DOWN: begin
        v_next = prod_dn[63:32];
        we     = 1'b1;
        waddr  = idx - IW'(1);
        wdata  = prod_dn[63:48];
        idx_next = idx - IW'(1);
        if (idx == IW'(1)) begin
          // restart from the reference going up, unless it is the last entry
          v_next     = {2'b00, base_pitch, 8'h00};
          idx_next   = REF_I;
          state_next = (REF_I == LAST_I) ? B_IDLE : B_UP;
        end
      end
      B_UP: begin
        v_next   = (|up_shift[33:32]) ? 32'hFFFF_FFFF : up_shift[31:0];
        we       = 1'b1;
        waddr    = idx + IW'(1);
        wdata    = v_next[31:16];
        idx_next = idx + IW'(1);
        if (idx + IW'(1) == LAST_I) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
    v   <= v_next;
    idx <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/ntt_div_pipe.sv =====
// Pipelined restoring divider: 22-bit dividend by 10-bit divisor, two bits a stage.
// No package dependency. Quotient is saturated to 16 bits at the output.
module ntt_div_pipe (
  input  logic        clk,
  input  logic        en,
  input  logic [21:0] dividend,
  input  logic [9:0]  divisor,
  output logic [15:0] quotient
);
  localparam int STAGES = 11;

  logic [21:0] num  [STAGES+1];
  logic [10:0] rem  [STAGES+1];
  logic [9:0]  dvs  [STAGES+1];

  always_comb begin
    num[0] = dividend;
    rem[0] = '0;
    dvs[0] = divisor;
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [21:0] n1, n2;
    logic [10:0] r1, r2;
    logic [11:0] t1, t2;
    always_comb begin
      t1 = {rem[s], num[s][21]};
      if (t1 >= {2'b00, dvs[s]}) begin
        r1 = 11'(t1 - {2'b00, dvs[s]});
        n1 = {num[s][20:0], 1'b1};
      end else begin
        r1 = t1[10:0];
        n1 = {num[s][20:0], 1'b0};
      end
      t2 = {r1, n1[21]};
      if (t2 >= {2'b00, dvs[s]}) begin
        r2 = 11'(t2 - {2'b00, dvs[s]});
        n2 = {n1[20:0], 1'b1};
      end else begin
        r2 = t2[10:0];
        n2 = {n1[20:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num[s+1] <= n2;
        rem[s+1] <= r2;
        dvs[s+1] <= dvs[s];
      end
    end
  end

  // zero divisor gives all ones, which also saturates
  always_comb begin
    if (dvs[STAGES] == '0 || |num[STAGES][21:16]) quotient = 16'hFFFF;
    else quotient = num[STAGES][15:0];
  end

endmodule

// ===== rtl/core/note_to_tone_timing_unit.sv =====
// Note-to-tone timing unit: table lookup and tempo scaling of note periods.
// Takes one note a cycle; the 11 divider stages set the depth. A held
// output beat stalls the whole pipe. After reset, and after each base_pitch
// write, the table builder runs and neither notes nor register writes are
// taken. Reset is synchronous, active high.
// Depends on ntt_pkg, ntt_table_build, ntt_div_pipe.
module note_to_tone_timing_unit #(
  parameter int NOTE_COUNT      = 88,
  parameter int REFERENCE_INDEX = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // note_idx[6:0], tone_length[22:7], mute_length[38:23]
  input  logic        s_tlast,   // last_note
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // freq_hz[15:0], tone_ms[31:16], wait_ms[48:32], index_error[49]
  output logic        m_tlast,   // last_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  import ntt_pkg::*;

  localparam int IW    = $clog2(NOTE_COUNT);
  localparam int DEPTH = 11;

  logic [6:0]  transpose;
  logic [9:0]  tempo;
  logic [21:0] base_pitch;
  logic        build_start, busy, booted;
  logic        cfg_acc;
  logic        adv, in_acc;
  logic [DEPTH-1:0] vld;
  logic [7:0]  sidx;
  logic        bad0;
  logic [IW-1:0] raddr;
  logic [15:0] rdata;
  logic [15:0] tone_q, mute_q;
  logic [DEPTH-1:0] err_d, last_d;
  logic [15:0] freq_r;
  logic        err_r;

  assign cfg_ready = booted && !busy;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign build_start = (!booted) ||
                       (cfg_acc && cfg_index == REG_BASE_PITCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_pitch <= BASE_PITCH_RST;
      transpose  <= TRANSPOSE_RST;
      tempo      <= TEMPO_RST;
      booted     <= 1'b0;
    end else begin
      booted <= 1'b1;
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_BASE_PITCH: base_pitch <= cfg_data;
          REG_TRANSPOSE:  transpose  <= cfg_data[6:0];
          REG_TEMPO:      tempo      <= cfg_data[9:0];
          default: ;
        endcase
      end
    end
  end

  ntt_table_build #(.NOTE_COUNT(NOTE_COUNT), .REFERENCE_INDEX(REFERENCE_INDEX)) u_build (
    .clk(clk), .rst(rst), .start(build_start),
    .base_pitch(build_start && booted ? cfg_data : base_pitch),
    .busy(busy), .rd_en(adv), .rd_addr(raddr), .rd_data(rdata)
  );

  // advance the pipe unless the output beat is held
  assign adv      = !(m_tvalid && !m_tready);
  assign s_tready = adv && !busy && booted && !build_start;
  assign in_acc   = s_tvalid && s_tready;

  assign sidx  = 8'(s_tdata[6:0]) + {transpose[6], transpose};
  assign bad0  = sidx[7] || (sidx >= 8'(NOTE_COUNT));
  assign raddr = bad0 ? '0 : sidx[IW-1:0];

  ntt_div_pipe u_tone (
    .clk(clk), .en(adv),
    .dividend(22'(s_tdata[22:7]) * 22'd60), .divisor(tempo), .quotient(tone_q)
  );
  ntt_div_pipe u_mute (
    .clk(clk), .en(adv),
    .dividend(22'(s_tdata[38:23]) * 22'd60), .divisor(tempo), .quotient(mute_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_d  <= {err_d[DEPTH-2:0], bad0};
      last_d <= {last_d[DEPTH-2:0], s_tlast};
      if (vld[0]) begin
        freq_r <= err_d[0] ? 16'd0 : rdata;
      end
      // hold the looked-up frequency alongside the divider
    end
  end

  // the frequency rides a small delay line to match the divider
  logic [15:0] fq [DEPTH-2];
  always_ff @(posedge clk) begin
    if (adv) begin
      fq[0] <= freq_r;
      for (int i = 1; i < DEPTH - 2; i++) fq[i] <= fq[i-1];
    end
  end
  assign err_r = err_d[DEPTH-1];

  assign m_tvalid = vld[DEPTH-1];
  assign m_tlast  = last_d[DEPTH-1];
  assign m_tdata  = {6'd0, err_r, 17'(tone_q) + 17'(mute_q), tone_q, fq[DEPTH-3]};

endmodule

// ===== bench/testbench.sv =====
// Testbench for note_to_tone_timing_unit: note table lookup and tempo scaling.
// Holds its own table builder and period scaler; depends on ntt_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ntt_pkg::*;

  typedef struct packed {
    logic [15:0] freq_hz;
    logic [15:0] tone_ms;
    logic [16:0] wait_ms;
    logic        index_error;
    logic        last_out;
  } tone_timing_t;

  class tone_scoreboard;
    logic [15:0]  pitch_table [88];
    logic [21:0]  base_pitch;
    logic [6:0]   transpose;
    logic [9:0]   tempo;
    tone_timing_t pending [$];
    int           errors;
    int           notes_seen;

    function void rebuild();
      logic [63:0] v;
      v = {42'd0, base_pitch} << 8;
      pitch_table[48] = v[31:16];
      for (int i = 47; i >= 0; i--) begin
        v = (v * 64'd4053909305) >> 32;
        pitch_table[i] = v[31:16];
      end
      v = {42'd0, base_pitch} << 8;
      for (int i = 49; i < 88; i++) begin
        v = (v * 64'd1137589835) >> 30;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        pitch_table[i] = v[31:16];
      end
    endfunction

    function void reset_state();
      base_pitch = BASE_PITCH_RST;
      transpose  = TRANSPOSE_RST;
      tempo      = TEMPO_RST;
      rebuild();
    endfunction

    function void write_reg(logic [1:0] idx, logic [21:0] val);
      case (idx)
        REG_BASE_PITCH: begin
          base_pitch = val;
          rebuild();
        end
        REG_TRANSPOSE: transpose = val[6:0];
        REG_TEMPO:     tempo = val[9:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] scale(logic [15:0] len);
      logic [31:0] q;
      if (tempo == 0) return 16'hFFFF;
      q = (len * 32'd60) / tempo;
      return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
    endfunction

    function void note_in(logic [6:0] note, logic [15:0] tl, logic [15:0] ml, logic lst);
      tone_timing_t e;
      int idx;
      logic [15:0] m;
      idx = int'(note) + int'($signed(transpose));
      e.index_error = !(idx >= 0 && idx < 88);
      e.freq_hz = e.index_error ? 16'd0 : pitch_table[idx];
      e.tone_ms = scale(tl);
      m = scale(ml);
      e.wait_ms = {1'b0, e.tone_ms} + {1'b0, m};
      e.last_out = lst;
      pending.push_back(e);
      notes_seen++;
    endfunction

    function void check(logic [55:0] d, logic lst);
      tone_timing_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.freq_hz) begin
        $error("freq_hz expected %0d actual %0d", e.freq_hz, d[15:0]); errors++;
      end
      if (d[31:16] !== e.tone_ms) begin
        $error("tone_ms expected %0d actual %0d", e.tone_ms, d[31:16]); errors++;
      end
      if (d[48:32] !== e.wait_ms) begin
        $error("wait_ms expected %0d actual %0d", e.wait_ms, d[48:32]); errors++;
      end
      if (d[49] !== e.index_error) begin
        $error("index_error expected %0d actual %0d", e.index_error, d[49]); errors++;
      end
      if (lst !== e.last_out) begin
        $error("last_out expected %0d actual %0d", e.last_out, lst); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0, s_tready, s_tlast = 0;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid, m_tready = 0, m_tlast;
  logic [55:0] m_tdata;
  logic        cfg_valid = 0, cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [21:0] cfg_data = '0;

  tone_scoreboard sb;
  int send_idle_pct, recv_idle_pct, quiet_cycles;

  always #5 clk = ~clk;

  note_to_tone_timing_unit dut (.*);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata, m_tlast);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // valid stays high after a beat so that notes can follow back to back
  task automatic send_note(logic [6:0] n, logic [15:0] tl, logic [15:0] ml, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {1'b0, ml, tl, n};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    sb.note_in(n, tl, ml, lst);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [21:0] val);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_notes(int count);
    logic [15:0] tl, ml;
    for (int i = 0; i < count; i++) begin
      tl = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
      ml = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
      send_note(7'($urandom), tl, ml, ($urandom_range(7) == 0));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(negedge clk);
    rst <= 0;
    // directed: field extremes, index bounds, transposition, tempo and base pitch limits, an unused register index
    send_note(7'd0, 16'd0, 16'd0, 0);
    send_note(7'd127, 16'hFFFF, 16'hFFFF, 1);
    send_note(7'd48, 16'd1000, 16'd500, 0);
    send_note(7'd87, 16'h5555, 16'hAAAA, 1);
    send_note(7'd88, 16'hAAAA, 16'h5555, 0);
    write_cfg(REG_TRANSPOSE, 22'h7F & 22'(-48));
    send_note(7'd47, 16'd10, 16'd10, 0);
    send_note(7'd48, 16'd10, 16'd10, 0);
    write_cfg(REG_TRANSPOSE, 22'd48);
    send_note(7'd39, 16'd10, 16'd10, 0);
    send_note(7'd40, 16'd10, 16'd10, 0);
    write_cfg(REG_TEMPO, 22'd1);
    send_note(7'd0, 16'hFFFF, 16'd1092, 1);
    write_cfg(REG_TEMPO, 22'd1023);
    send_note(7'd1, 16'hFFFF, 16'hFFFF, 0);
    write_cfg(REG_TEMPO, 22'd0);
    send_note(7'd2, 16'd0, 16'd0, 0);
    write_cfg(REG_BASE_PITCH, 22'h3FFFFF);
    send_note(7'd40, 16'd1, 16'd2, 0);
    send_note(7'd100, 16'd1, 16'd2, 0);
    write_cfg(REG_BASE_PITCH, 22'd256);
    send_note(7'd0, 16'd1, 16'd2, 0);
    send_note(7'd60, 16'd1, 16'd2, 1);
    write_cfg(2'd3, 22'h3FFFFF);
    send_note(7'd10, 16'd7, 16'd7, 0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 10 : 0;
      for (int k = 0; k < 3; k++) begin
        write_cfg(REG_BASE_PITCH, 22'($urandom_range(4194303, 256)));
        write_cfg(REG_TRANSPOSE, 22'(7'($urandom_range(96)) - 7'd48));
        write_cfg(REG_TEMPO, 22'($urandom_range(1023, 1)));
        random_notes(55);
        // hold until the block has delivered everything
        drain();
        random_notes(55);
      end
    end
    drain();
    $display("covered %0d notes over three idle regimes with table rebuilds", sb.notes_seen);
    $display("transpose, tempo and base pitch extremes and invalid indexes included");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
